/* src/lnsu_pkg.sv */
// Shared types and constants for the Laplace noise sampler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lnsu_pkg;

    // Item field widths
    localparam int CENTER_W   = 32;
    localparam int DRAW_W     = 32;
    localparam int SCALE_W    = 32;
    localparam int OUT_W      = 48;

    // Uniform input width default (16..32)
    localparam int UNIFORM_BITS_DEF = 32;

    // Log unit geometry: Q1.31 mantissa, Q0.32 fraction, one bit per cell
    localparam int Y_W       = 32;
    localparam int F_W       = 32;
    localparam int LOG_STEPS = 32;
    localparam int EXP_W     = 5;
    localparam int D_W       = EXP_W + F_W;      // -log2 in Q5.32
    localparam int L_W       = D_W + 1;          // -ln after scaling by ln2
    localparam int NOISE_W   = L_W + 1;
    localparam int SUM_W     = OUT_W + 1;

    localparam logic [31:0]      LN2_Q32     = 32'hB172_17F8;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;
    localparam logic [OUT_W-1:0] OUT_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_MIN     = 48'h8000_0000_0000;

    // Sideband that rides along with each word
    typedef struct packed {
        logic                positive;   // u >= 1/2
        logic                zero;       // u == 0
        logic [EXP_W-1:0]    exp_pos;    // leading one position of m
        logic [CENTER_W-1:0] mean;
    } lnsu_side_t;

    // Word handed from cell to cell in the log chain
    typedef struct packed {
        logic [Y_W-1:0] y;
        logic [F_W-1:0] frac;
        lnsu_side_t     side;
    } lnsu_log_t;

endpackage

/* src/lnsu_front.sv */
// Front end: folds u into m = 1 - 2|r| (scaled), finds its leading one, normalizes.
// Depends on lnsu_pkg. Three stages with bubble-collapsing handshake.
`timescale 1ns / 1ps

module lnsu_front
    import lnsu_pkg::*;
#(
    parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CENTER_W-1:0] center_value,
    input  logic [DRAW_W-1:0]   uniform_draw,
    output logic                out_valid,
    input  logic                out_ready,
    output lnsu_log_t           out_data
);

    localparam int NST = 3;

    logic [NST-1:0] valid_reg;
    logic [NST:0]   rdy;

    logic [UNIFORM_BITS-1:0] m1_reg, m1_next;
    logic [UNIFORM_BITS-1:0] m2_reg;
    lnsu_side_t              side1_reg, side1_next;
    lnsu_side_t              side2_reg, side2_next;
    lnsu_log_t               out_reg, out_next;

    logic [UNIFORM_BITS-1:0] u;
    logic [UNIFORM_BITS:0]   m_flip;
    logic [EXP_W-1:0]        lead;
    logic [Y_W-1:0]          m_wide;

    // Ready chain: a stage takes a word when empty or when it moves on
    always_comb begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NST-1];
    assign out_data  = out_reg;

    // Stage 1: mirror the upper half of u
    always_comb begin
        u      = uniform_draw[UNIFORM_BITS-1:0];
        m_flip = {1'b1, {UNIFORM_BITS{1'b0}}} - {1'b0, u};
        side1_next.positive = u[UNIFORM_BITS-1];
        side1_next.zero     = (u == '0);
        side1_next.exp_pos  = '0;
        side1_next.mean     = center_value;
        m1_next = u[UNIFORM_BITS-1] ? m_flip[UNIFORM_BITS-1:0] : u;
    end

    // Stage 2: leading one of m
    always_comb begin
        lead = '0;
        for (int i = 0; i < UNIFORM_BITS; i++) begin
            if (m1_reg[i]) begin
                lead = EXP_W'(i);
            end
        end
        side2_next         = side1_reg;
        side2_next.exp_pos = lead;
    end

    // Stage 3: shift m up to Q1.31
    always_comb begin
        m_wide        = Y_W'(m2_reg);
        out_next.y    = m_wide << (EXP_W'(Y_W - 1) - side2_reg.exp_pos);
        out_next.frac = '0;
        out_next.side = side2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) valid_reg[0] <= in_valid;
            if (rdy[1]) valid_reg[1] <= valid_reg[0];
            if (rdy[2]) valid_reg[2] <= valid_reg[1];
        end
        if (rdy[0] && in_valid) begin
            m1_reg    <= m1_next;
            side1_reg <= side1_next;
        end
        if (rdy[1] && valid_reg[0]) begin
            m2_reg    <= m1_reg;
            side2_reg <= side2_next;
        end
        if (rdy[2] && valid_reg[1]) begin
            out_reg <= out_next;
        end
    end

endmodule

/* src/lnsu_log_cell.sv */
// One cell of the log2 chain: squares the mantissa and emits one fraction bit.
// Depends on lnsu_pkg. Cells are chained, one word per cycle while the output is not held.
`timescale 1ns / 1ps

module lnsu_log_cell
    import lnsu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  lnsu_log_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output lnsu_log_t out_data
);

    logic       valid_reg;
    lnsu_log_t  data_reg, data_next;

    logic [2*Y_W-1:0] sq;
    logic [Y_W:0]     sq_top;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // y <- y^2 in Q1.31; renormalize when it reaches 2.0
    always_comb begin
        sq     = 64'(in_data.y) * 64'(in_data.y);
        sq_top = sq[2*Y_W-1:Y_W-1];
        data_next      = in_data;
        data_next.y    = sq_top[Y_W] ? sq_top[Y_W:1] : sq_top[Y_W-1:0];
        data_next.frac = {in_data.frac[F_W-2:0], sq_top[Y_W]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    // Mantissa stays normalized in [1,2) unless the draw was zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !data_reg.side.zero |-> data_reg.y[Y_W-1])
        else $error("log cell mantissa lost normalization");

endmodule

/* src/lnsu_back.sv */
// Back end: log2 -> ln, times the scale, plus or minus the mean, clamp to 48 bits.
// Depends on lnsu_pkg. Six stages; the last one is the output register.
`timescale 1ns / 1ps

module lnsu_back
    import lnsu_pkg::*;
#(
    parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [SCALE_W-1:0] noise_scale,
    input  logic               in_valid,
    output logic               in_ready,
    input  lnsu_log_t          in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [OUT_W-1:0]   noisy_sample,
    output logic               saturated
);

    localparam int NST = 6;

    logic [NST-1:0] valid_reg;
    logic [NST:0]   rdy;

    lnsu_side_t side_reg [NST-1];

    logic [D_W-1:0]          d_reg, d_next;
    logic [2*F_W-1:0]        ln_lo_reg, ln_lo_next;
    logic [D_W-1:0]          ln_hi_reg, ln_hi_next;
    logic [L_W-1:0]          l_reg, l_next;
    logic [2*SCALE_W-1:0]    sc_lo_reg, sc_lo_next;
    logic [L_W-1:0]          sc_hi_reg, sc_hi_next;
    logic [NOISE_W-1:0]      noise_reg, noise_next;
    logic [OUT_W-1:0]        sample_reg, sample_next;
    logic                    sat_reg, sat_next;

    logic [EXP_W-1:0]        int_part;
    logic [SUM_W-1:0]        mean_ext, noise_ext, sum;

    always_comb begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign in_ready     = rdy[0];
    assign out_valid    = valid_reg[NST-1];
    assign noisy_sample = sample_reg;
    assign saturated    = sat_reg;

    // D = (U-1-p) - log2(y) in Q5.32
    always_comb begin
        int_part = EXP_W'(UNIFORM_BITS - 1) - in_data.side.exp_pos;
        d_next   = {int_part, {F_W{1'b0}}} - {{EXP_W{1'b0}}, in_data.frac};
    end

    // Times ln 2, split into high and low parts
    always_comb begin
        ln_lo_next = 64'(d_reg[F_W-1:0]) * 64'(LN2_Q32);
        ln_hi_next = D_W'(d_reg[D_W-1:F_W]) * D_W'(LN2_Q32);
        l_next     = L_W'(ln_hi_reg) + L_W'(ln_lo_reg[2*F_W-1:F_W]);
    end

    // Times the scale, same split
    always_comb begin
        sc_lo_next = 64'(l_reg[F_W-1:0]) * 64'(noise_scale);
        sc_hi_next = L_W'(l_reg[L_W-1:F_W]) * L_W'(noise_scale);
        noise_next = NOISE_W'(sc_hi_reg) + NOISE_W'(sc_lo_reg[2*SCALE_W-1:SCALE_W]);
    end

    // Add to the mean and clamp
    always_comb begin
        mean_ext  = {{(SUM_W - CENTER_W){side_reg[4].mean[CENTER_W-1]}}, side_reg[4].mean};
        noise_ext = {{(SUM_W - NOISE_W){1'b0}}, noise_reg};
        sum       = side_reg[4].positive ? mean_ext + noise_ext : mean_ext - noise_ext;
        if (side_reg[4].zero) begin
            sample_next = OUT_MIN;
            sat_next    = 1'b1;
        end else if (sum[SUM_W-1] != sum[SUM_W-2]) begin
            sample_next = sum[SUM_W-1] ? OUT_MIN : OUT_MAX;
            sat_next    = 1'b1;
        end else begin
            sample_next = sum[OUT_W-1:0];
            sat_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) valid_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
        if (rdy[0] && in_valid) begin
            d_reg       <= d_next;
            side_reg[0] <= in_data.side;
        end
        if (rdy[1] && valid_reg[0]) begin
            ln_lo_reg   <= ln_lo_next;
            ln_hi_reg   <= ln_hi_next;
            side_reg[1] <= side_reg[0];
        end
        if (rdy[2] && valid_reg[1]) begin
            l_reg       <= l_next;
            side_reg[2] <= side_reg[1];
        end
        if (rdy[3] && valid_reg[2]) begin
            sc_lo_reg   <= sc_lo_next;
            sc_hi_reg   <= sc_hi_next;
            side_reg[3] <= side_reg[2];
        end
        if (rdy[4] && valid_reg[3]) begin
            noise_reg   <= noise_next;
            side_reg[4] <= side_reg[3];
        end
        if (rdy[5] && valid_reg[4]) begin
            sample_reg <= sample_next;
            sat_reg    <= sat_next;
        end
    end

endmodule

/* src/laplace_noise_sampler_unit.sv */
// Pipeline from input word to result: 3 front stages, 32 log cells, 6 back stages.
// One word per cycle while the output is not held; each log cell squares once, each stage holds one word.
// The handshake collapses bubbles, so input keeps flowing while a result waits, until every stage is full.
// Reset (aresetn low, synchronous) empties the pipeline and sets the scale to 1.0.
// Depends on lnsu_pkg, lnsu_front, lnsu_log_cell, lnsu_back.
`timescale 1ns / 1ps

module laplace_noise_sampler_unit
    import lnsu_pkg::*;
#(
    parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Scale register, Q16.16
    input  logic                       cfg_we,
    input  logic [SCALE_W-1:0]         cfg_wdata,
    // Input words
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [CENTER_W+DRAW_W-1:0] s_tdata,   // [31:0] center_value, [63:32] uniform_draw
    // Result words
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_W-1:0]           m_tdata,   // [47:0] noisy_sample
    output logic                       m_tuser    // [0] saturated
);

    logic [SCALE_W-1:0] noise_scale_reg;

    lnsu_log_t chain_data  [LOG_STEPS+1];
    logic      chain_valid [LOG_STEPS+1];
    logic      chain_ready [LOG_STEPS+1];

    // Scale register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_scale_reg <= SCALE_RESET;
        end else if (cfg_we) begin
            noise_scale_reg <= cfg_wdata;
        end
    end

    lnsu_front #(
        .UNIFORM_BITS(UNIFORM_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .center_value (s_tdata[CENTER_W-1:0]),
        .uniform_draw (s_tdata[CENTER_W+DRAW_W-1:CENTER_W]),
        .out_valid    (chain_valid[0]),
        .out_ready    (chain_ready[0]),
        .out_data     (chain_data[0])
    );

    // Row of log2 cells, one fraction bit each
    for (genvar g = 0; g < LOG_STEPS; g++) begin : g_cell
        lnsu_log_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    lnsu_back #(
        .UNIFORM_BITS(UNIFORM_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .noise_scale  (noise_scale_reg),
        .in_valid     (chain_valid[LOG_STEPS]),
        .in_ready     (chain_ready[LOG_STEPS]),
        .in_data      (chain_data[LOG_STEPS]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .noisy_sample (m_tdata),
        .saturated    (m_tuser)
    );

    // A clamped result sits on one of the two bounds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata == OUT_MIN || m_tdata == OUT_MAX))
        else $error("saturated result not at a bound");

    // Input only stalls when every stage is full and the output is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // Pipeline comes out of reset empty
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

endmodule

/* dv/laplace_noise_sampler_unit_test.sv */
// Self-checking bench for laplace_noise_sampler_unit: directed table, then random words.
// Each word is checked against its typed row value or an in-bench Laplace sample predictor; needs lnsu_pkg.
`timescale 1ns / 1ps

module laplace_noise_sampler_unit_test;
    import lnsu_pkg::*;

    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     DRAIN_CYCLES = 60;     // beyond the pipeline depth
    localparam int     LONG_HOLD    = 300;    // receiver stall, well past pipeline depth
    localparam int     PHASE_WORDS  = 200;
    localparam int     NUM_PHASES   = 7;
    localparam longint SAMPLE_HI    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAMPLE_LO    = -SAMPLE_HI - 1;

    typedef enum logic [1:0] {SRC35_SINK65, SRC65_SINK35, NO_GAPS} gap_mode_t;

    typedef struct packed {
        logic [OUT_W-1:0] sample;
        logic             sat;
    } sample_t;

    typedef struct packed {
        logic [CENTER_W-1:0] center;
        logic [DRAW_W-1:0]   draw;
        logic                typed;    // expected value given in the row
        logic [OUT_W-1:0]    sample;
        logic                sat;
    } stim_row_t;

    localparam int N_DIRECTED = 20;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [SCALE_W-1:0]         cfg_wdata = '0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [CENTER_W+DRAW_W-1:0] s_tdata   = '0;  // [31:0] center_value, [63:32] uniform_draw
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [OUT_W-1:0]           m_tdata;         // [47:0] noisy_sample
    logic                       m_tuser;         // [0] saturated

    gap_mode_t      gap_mode      = SRC35_SINK65;
    logic [31:0]    scale_model   = SCALE_RESET;
    sample_t        pending_samples[$];
    int             error_count   = 0;
    int             cycle_count   = 0;
    int             hold_left     = 0;
    bit             long_hold_req = 1'b0;
    bit             long_hold_used = 1'b0;

    // Directed words: extremes, u = 0, u = 1/2, both tails
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{32'h0000_0000, 32'h8000_0000, 1'b1, 48'h0000_0000_0000, 1'b0},  // u = 1/2
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 48'h0000_7FFF_FFFF, 1'b0},
        '{32'h8000_0000, 32'h8000_0000, 1'b1, 48'hFFFF_8000_0000, 1'b0},
        '{32'h0001_0000, 32'h0000_0000, 1'b1, OUT_MIN,            1'b1},  // u = 0
        '{32'h7FFF_FFFF, 32'h0000_0000, 1'b1, OUT_MIN,            1'b1},
        '{32'h8000_0000, 32'h0000_0000, 1'b1, OUT_MIN,            1'b1},
        '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0, 1'b0},  // deepest positive tail
        '{32'h8000_0000, 32'h0000_0001, 1'b0, '0, 1'b0},  // deepest negative tail
        '{32'h7FFF_FFFF, 32'h0000_0001, 1'b0, '0, 1'b0},
        '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '0, 1'b0},
        '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0, 1'b0},  // just below one half
        '{32'h0000_0001, 32'h8000_0001, 1'b0, '0, 1'b0},  // just above one half
        '{32'h0000_0000, 32'h4000_0000, 1'b0, '0, 1'b0},  // noise = -ln 2
        '{32'h0000_0000, 32'hC000_0000, 1'b0, '0, 1'b0},  // noise = +ln 2
        '{32'h5555_5555, 32'h0000_0002, 1'b0, '0, 1'b0},
        '{32'hAAAA_AAAA, 32'hFFFF_FFFE, 1'b0, '0, 1'b0},
        '{32'h5555_5555, 32'h5555_5555, 1'b0, '0, 1'b0},
        '{32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, '0, 1'b0},
        '{32'h1234_5678, 32'h1234_5678, 1'b0, '0, 1'b0},
        '{32'hFEDC_BA98, 32'hFEDC_BA98, 1'b0, '0, 1'b0}
    };

    laplace_noise_sampler_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // -log2(m / 2^31) in Q.32, by repeated squaring of the Q1.31 mantissa
    function automatic logic [63:0] neg_log2_q32(input logic [32:0] m);
        int          msb;
        logic [63:0] y;
        logic [31:0] f;
        msb = 0;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) msb = i;
        end
        y = 64'(m) << (31 - msb);
        f = '0;
        for (int i = 0; i < 32; i++) begin
            y = (y * y) >> 31;
            f = {f[30:0], 1'b0};
            if (y >= 64'h1_0000_0000) begin
                f[0] = 1'b1;
                y    = y >> 1;
            end
        end
        return (64'(31 - msb) << 32) - 64'(f);
    endfunction

    // Expected sample: mean +/- scale * -ln(1 - 2|u - 1/2|), clamped to 48 bits
    function automatic sample_t laplace_sample(input logic signed [31:0] center,
                                               input logic [31:0] draw,
                                               input logic [31:0] scale);
        logic [32:0]  m;
        logic [127:0] prod;
        logic [63:0]  ln_q32;
        logic [63:0]  noise;
        longint       acc;
        sample_t      r;
        if (draw == '0) begin
            r.sample = OUT_MIN;
            r.sat    = 1'b1;
            return r;
        end
        m      = draw[31] ? (33'h1_0000_0000 - 33'(draw)) : 33'(draw);
        prod   = 128'(neg_log2_q32(m)) * 128'(LN2_Q32);
        ln_q32 = prod[95:32];
        prod   = 128'(ln_q32) * 128'(scale);
        noise  = prod[95:32];
        acc    = longint'(center) + (draw[31] ? longint'(noise) : -longint'(noise));
        r.sat  = 1'b0;
        if (acc > SAMPLE_HI) begin
            acc   = SAMPLE_HI;
            r.sat = 1'b1;
        end else if (acc < SAMPLE_LO) begin
            acc   = SAMPLE_LO;
            r.sat = 1'b1;
        end
        r.sample = acc[OUT_W-1:0];
        return r;
    endfunction

    function automatic int src_idle_pct(input gap_mode_t mode);
        case (mode)
            SRC35_SINK65: return 35;
            SRC65_SINK35: return 65;
            default:      return 0;
        endcase
    endfunction

    function automatic int sink_idle_pct(input gap_mode_t mode);
        case (mode)
            SRC35_SINK65: return 65;
            SRC65_SINK35: return 35;
            default:      return 0;
        endcase
    endfunction

    // Draws weighted toward the tails and the midpoint, where the log is hardest
    function automatic logic [31:0] random_draw();
        int pick;
        pick = $urandom_range(0, 31);
        if (pick == 0) return '0;
        if (pick < 6)  return 32'($urandom_range(1, 1023));
        if (pick < 11) return 32'hFFFF_FFFF - 32'($urandom_range(0, 1023));
        if (pick < 15) return 32'h8000_0000 + 32'($urandom_range(0, 2047)) - 32'd1024;
        if (pick < 20) return $urandom >> $urandom_range(0, 31);
        return $urandom;
    endfunction

    function automatic logic [31:0] random_center();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word, with random gaps ahead of it; book its result once taken
    task automatic send_word(input logic [31:0] center, input logic [31:0] draw,
                             input sample_t want);
        while ($urandom_range(0, 99) < src_idle_pct(gap_mode)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {draw, center};
        do @(posedge aclk); while (!s_tready);
        pending_samples.push_back(want);
    endtask

    // Scale is only rewritten with the pipeline empty
    task automatic write_scale(input logic [31:0] value);
        while (pending_samples.size() != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        scale_model  = value;
    endtask

    // Receiver: check each word, random back-pressure, one long hold on request
    always @(posedge aclk) begin : sink
        sample_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_samples.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual sample %h sat %b",
                             $time, m_tdata, m_tuser);
                    error_count++;
                end else begin
                    want = pending_samples.pop_front();
                    if (m_tdata !== want.sample) begin
                        $display("%0t: noisy_sample mismatch: expected %h, actual %h",
                                 $time, want.sample, m_tdata);
                        error_count++;
                    end
                    if (m_tuser !== want.sat) begin
                        $display("%0t: saturated mismatch: expected %b, actual %b",
                                 $time, want.sat, m_tuser);
                        error_count++;
                    end
                end
            end
            if (long_hold_req && !long_hold_used) begin
                hold_left      = LONG_HOLD;
                long_hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct(gap_mode));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [31:0] center;
        logic [31:0] draw;
        logic [31:0] scale;
        sample_t     want;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table at the reset scale
        foreach (directed_rows[i]) begin
            if (directed_rows[i].typed) begin
                want.sample = directed_rows[i].sample;
                want.sat    = directed_rows[i].sat;
            end else begin
                want = laplace_sample(directed_rows[i].center, directed_rows[i].draw,
                                      scale_model);
            end
            send_word(directed_rows[i].center, directed_rows[i].draw, want);
        end
        s_tvalid <= 1'b0;

        // Random phases, each with its own scale and gap pattern
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       scale = 32'hFFFF_FFFF;
                1:       scale = 32'h0000_0000;
                3:       scale = 32'h0000_0001;
                5:       scale = SCALE_RESET;
                default: scale = $urandom;
            endcase
            write_scale(scale);
            gap_mode <= (ph < 2) ? SRC35_SINK65 : (ph < 5) ? SRC65_SINK35 : NO_GAPS;
            if (ph == 5) long_hold_req <= 1'b1;  // fill the pipe, stall the input
            @(posedge aclk);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                center = random_center();
                draw   = random_draw();
                send_word(center, draw, laplace_sample(center, draw, scale_model));
            end
            s_tvalid <= 1'b0;
        end

        // Drain, then make sure nothing extra shows up
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
